FILE: src/cqats_pkg.sv
// Shared types, codes and constants of the command queue scheduler.
`timescale 1ns / 1ps

package cqats_pkg;

    // Field widths
    localparam int CMD_W       = 3;
    localparam int TAG_W       = 8;
    localparam int TIME_W      = 32;
    localparam int ACTION_W    = 2;
    localparam int COUNT_OUT_W = 4;
    localparam int GAP_W       = 16;
    localparam int PERIOD_W    = 20;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 20;

    localparam int DEFAULT_QUEUE_DEPTH = 8;

    // Input commands
    localparam logic [CMD_W-1:0] CMD_TICK        = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ENQUEUE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FRAME_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STATUS_RESP = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESTART     = 3'd4;

    // Result actions
    localparam logic [ACTION_W-1:0] ACT_NONE     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SEND     = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TIMEOUT  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_OVERFLOW = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POST_SEND   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INTER_GAP   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_POLL_PERIOD = 2'd3;

    // Configuration reset values
    localparam logic [GAP_W-1:0]    ACK_TIMEOUT_RST = 16'd2000;
    localparam logic [GAP_W-1:0]    POST_SEND_RST   = 16'd100;
    localparam logic [GAP_W-1:0]    INTER_GAP_RST   = 16'd50;
    localparam logic [PERIOD_W-1:0] POLL_PERIOD_RST = 20'd10000;

    // One queue entry: poll flag over the frame tag
    typedef struct packed {
        logic             poll;
        logic [TAG_W-1:0] tag;
    } entry_t;

    localparam entry_t POLL_ENTRY = '{poll: 1'b1, tag: '0};

endpackage

FILE: src/command_queue_ack_timeout_scheduler.sv
// Half-duplex command scheduler: frame queue, send gaps, ack timeout and status poll.
`timescale 1ns / 1ps

// The block takes one item per clock unless in_stall is high. An accepted item lands
// in an input register; once the result register is free, one pass of logic (two
// 32-bit stamp subtractions with their compares, queue pointer update, one queue
// write) produces the result, which is held in the result register until taken and
// stays there for as long as the receiver stalls. While a result waits, one more
// item can sit in the input register. The frame queue is a QUEUE_DEPTH x 9 bit
// memory with one write port; the head entry is kept in a register that is reloaded
// from the memory (or the entry being written) at every edge, so no clearing pass
// is needed after reset. pending_count gives the low four bits of the queue fill.
module command_queue_ack_timeout_scheduler #(
    parameter int QUEUE_DEPTH = cqats_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // item input channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [cqats_pkg::CMD_W-1:0]        command,
    input  logic [cqats_pkg::TAG_W-1:0]        frame_tag,
    input  logic [cqats_pkg::TIME_W-1:0]       now_ms,
    // result output channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [cqats_pkg::ACTION_W-1:0]     action,
    output logic [cqats_pkg::TAG_W-1:0]        sent_tag,
    output logic                               sent_is_poll,
    output logic                               awaiting_reply,
    output logic [cqats_pkg::COUNT_OUT_W-1:0]  pending_count,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cqats_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cqats_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cqats_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(QUEUE_DEPTH);

    // Configuration registers
    logic [GAP_W-1:0]    ack_timeout_reg;
    logic [GAP_W-1:0]    post_send_reg;
    logic [GAP_W-1:0]    inter_gap_reg;
    logic [PERIOD_W-1:0] poll_period_reg;

    // Input register
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [TIME_W-1:0] now_reg;

    // Scheduler state
    entry_t            pending_store_mem [QUEUE_DEPTH];
    entry_t            head_entry_reg;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              waiting_reg, waiting_next;
    logic              sent_valid_reg, sent_valid_next;
    logic [TIME_W-1:0] send_stamp_reg, send_stamp_next;
    logic [TIME_W-1:0] poll_stamp_reg, poll_stamp_next;

    // Result register
    logic                   out_valid_reg;
    logic [ACTION_W-1:0]    action_reg, action_next;
    logic [TAG_W-1:0]       sent_tag_reg, sent_tag_next;
    logic                   sent_poll_reg, sent_poll_next;
    logic                   waiting_out_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;

    // Step signals
    logic              advance;
    logic              drop_req;
    logic [PTR_W-1:0]  head_drop;
    logic [CNT_W-1:0]  count_drop;
    logic              push_req;
    entry_t            push_entry;
    logic              push_en;
    logic [PTR_W-1:0]  push_slot;
    logic [SUM_W-1:0]  tail_sum;
    logic [TIME_W-1:0] since_send;
    logic [TIME_W-1:0] since_poll;
    logic              timed_out;
    logic              gap_ok;
    logic              poll_due;
    logic [CNT_W+COUNT_OUT_W-1:0] count_wide;

    // Move the input register into the result register when it is free
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign cfg_ready = 1'b1;

    // Stamp differences wrap modulo 2^32
    assign since_send = now_reg - send_stamp_reg;
    assign since_poll = now_reg - poll_stamp_reg;
    assign timed_out  = since_send >= {{(TIME_W - GAP_W){1'b0}}, ack_timeout_reg};
    assign gap_ok = (since_send >= {{(TIME_W - GAP_W){1'b0}}, inter_gap_reg}) &&
                    !(sent_valid_reg &&
                      (since_send < {{(TIME_W - GAP_W){1'b0}}, post_send_reg}));

    // Decide drops, pushes and the result of the held item
    always_comb
    begin
        drop_req        = 1'b0;
        push_req        = 1'b0;
        push_entry      = POLL_ENTRY;
        waiting_next    = waiting_reg;
        sent_valid_next = sent_valid_reg;
        send_stamp_next = send_stamp_reg;
        poll_stamp_next = poll_stamp_reg;
        action_next     = ACT_NONE;
        sent_tag_next   = '0;
        sent_poll_next  = 1'b0;
        poll_due        = 1'b0;
        case (cmd_reg)
            CMD_TICK:
            begin
                if (waiting_reg)
                begin
                    if (timed_out)
                    begin
                        drop_req        = 1'b1;
                        waiting_next    = 1'b0;
                        poll_stamp_next = now_reg;
                        action_next     = ACT_TIMEOUT;
                    end
                end
                else if (count_reg != '0 && gap_ok)
                begin
                    sent_tag_next   = head_entry_reg.tag;
                    sent_poll_next  = head_entry_reg.poll;
                    send_stamp_next = now_reg;
                    sent_valid_next = 1'b1;
                    waiting_next    = 1'b1;
                    action_next     = ACT_SEND;
                end
                // poll stamp may just have moved to now
                poll_due = (waiting_reg && timed_out) ? (poll_period_reg == '0)
                         : (since_poll >= {{(TIME_W - PERIOD_W){1'b0}}, poll_period_reg});
                if (!waiting_next && count_drop == '0 && poll_due)
                begin
                    push_req        = 1'b1;
                    poll_stamp_next = now_reg;
                end
            end
            CMD_ENQUEUE:
            begin
                push_req   = 1'b1;
                push_entry = '{poll: 1'b0, tag: tag_reg};
                if (count_reg == FULL_CNT)
                begin
                    action_next = ACT_OVERFLOW;
                end
            end
            CMD_FRAME_START:
            begin
                if (waiting_reg)
                begin
                    drop_req        = 1'b1;
                    waiting_next    = 1'b0;
                    poll_stamp_next = now_reg;
                end
            end
            CMD_STATUS_RESP:
            begin
                if (waiting_reg)
                begin
                    drop_req     = 1'b1;
                    waiting_next = 1'b0;
                end
                poll_stamp_next = now_reg;
            end
            CMD_RESTART:
            begin
                waiting_next    = 1'b0;
                send_stamp_next = '0;
                poll_stamp_next = '0;
                sent_valid_next = 1'b0;
                push_req        = 1'b1;
                if (count_reg == FULL_CNT)
                begin
                    action_next = ACT_OVERFLOW;
                end
            end
            default:
            begin
                action_next = ACT_NONE;
            end
        endcase
    end

    // Drop the head entry when asked and the queue holds one
    assign head_drop  = (drop_req && count_reg != '0)
                      ? ((head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1)) : head_reg;
    assign count_drop = (drop_req && count_reg != '0) ? count_reg - CNT_W'(1) : count_reg;

    // Push at the tail unless the queue is full
    assign tail_sum  = SUM_W'(head_drop) + SUM_W'(count_drop);
    assign push_slot = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM)
                                               : PTR_W'(tail_sum);
    assign push_en   = advance && push_req && (count_drop != FULL_CNT);

    assign head_next  = advance ? head_drop : head_reg;
    assign count_next = push_en ? count_drop + CNT_W'(1)
                                : (advance ? count_drop : count_reg);
    assign count_wide = {{COUNT_OUT_W{1'b0}}, count_next};

    // Write the queue memory and reload the head entry
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            pending_store_mem[push_slot] <= push_entry;
        end
        if (push_en && push_slot == head_next)
        begin
            head_entry_reg <= push_entry;
        end
        else
        begin
            head_entry_reg <= pending_store_mem[head_next];
        end
    end

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
            post_send_reg   <= POST_SEND_RST;
            inter_gap_reg   <= INTER_GAP_RST;
            poll_period_reg <= POLL_PERIOD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACK_TIMEOUT: ack_timeout_reg <= cfg_data[GAP_W-1:0];
                REG_POST_SEND:   post_send_reg   <= cfg_data[GAP_W-1:0];
                REG_INTER_GAP:   inter_gap_reg   <= cfg_data[GAP_W-1:0];
                REG_POLL_PERIOD: poll_period_reg <= cfg_data[PERIOD_W-1:0];
                default:         poll_period_reg <= poll_period_reg;
            endcase
        end
    end

    // Hold the accepted item until it moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= command;
            tag_reg <= frame_tag;
            now_reg <= now_ms;
        end
    end

    // Advance the scheduler state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            waiting_reg    <= 1'b0;
            sent_valid_reg <= 1'b0;
            send_stamp_reg <= '0;
            poll_stamp_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (advance)
            begin
                waiting_reg    <= waiting_next;
                sent_valid_reg <= sent_valid_next;
                send_stamp_reg <= send_stamp_next;
                poll_stamp_reg <= poll_stamp_next;
            end
        end
    end

    // Load the result register, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            action_reg      <= action_next;
            sent_tag_reg    <= sent_tag_next;
            sent_poll_reg   <= sent_poll_next;
            waiting_out_reg <= waiting_next;
            count_out_reg   <= count_wide[COUNT_OUT_W-1:0];
        end
    end

    assign out_valid      = out_valid_reg;
    assign action         = action_reg;
    assign sent_tag       = sent_tag_reg;
    assign sent_is_poll   = sent_poll_reg;
    assign awaiting_reply = waiting_out_reg;
    assign pending_count  = count_out_reg;

    // Checks on queue and result consistency
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("queue fill exceeds depth");

    assert property (@(posedge clk) disable iff (!rst_n) waiting_reg |-> count_reg != '0)
        else $error("waiting for a reply with an empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == ACT_SEND) |-> waiting_out_reg)
        else $error("send result without awaiting reply");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg != ACT_SEND) |-> (sent_tag_reg == '0 && !sent_poll_reg))
        else $error("sent fields set on a result that is not a send");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && action_reg == ACT_OVERFLOW) |-> count_reg == FULL_CNT)
        else $error("overflow reported while the queue is not full");

endmodule
